@@ hw/rtl/blr_pkg.sv @@
package blr_pkg;

  // coordinate and field widths
  localparam int COORD_BITS = 12;
  localparam int COLOR_BITS = 16;
  localparam int PITCH_BITS = 13;
  localparam int INDEX_BITS = 24;
  localparam int ERR_BITS   = COORD_BITS + 2;
  localparam int PROD_BITS  = PITCH_BITS + COORD_BITS;
  localparam int SUM_BITS   = (PROD_BITS + 1 > INDEX_BITS) ? PROD_BITS + 1 : INDEX_BITS;

  // row pitch after reset
  localparam logic [PITCH_BITS-1:0] PITCH_RESET = PITCH_BITS'(640);

  // queue between front and back
  localparam int Q_DEPTH    = 4;
  localparam int Q_PTR_BITS = $clog2(Q_DEPTH);
  localparam int Q_CNT_BITS = $clog2(Q_DEPTH + 1);

  // input transaction kinds
  localparam logic KIND_START = 1'b0;
  localparam logic KIND_TICK  = 1'b1;

  typedef logic [COORD_BITS-1:0] coord_t;
  typedef logic [COLOR_BITS-1:0] color_t;
  typedef logic [PITCH_BITS-1:0] pitch_t;
  typedef logic [INDEX_BITS-1:0] index_t;

  // one pixel handed from front to back
  typedef struct packed {
    coord_t x;
    coord_t y;
    color_t color;
    logic   last;
  } pix_t;

  // one finished pixel write
  typedef struct packed {
    index_t index;
    color_t color;
    logic   last;
  } wr_t;

endpackage

@@ hw/rtl/blr_front.sv @@
module blr_front
  import blr_pkg::*;
(
  input  logic   clk,
  input  logic   rst_n,
  input  logic   accept,
  input  logic   in_kind,
  input  coord_t in_x_start,
  input  coord_t in_y_start,
  input  coord_t in_x_end,
  input  coord_t in_y_end,
  input  color_t in_line_color,
  output logic   pix_push,
  output pix_t   pix
);

  typedef enum logic [3:0] {
    MODE_H    = 4'b0001,
    MODE_V    = 4'b0010,
    MODE_YMAJ = 4'b0100,
    MODE_XMAJ = 4'b1000
  } mode_t;

  logic                       active_r, active_nxt;
  mode_t                      mode_r, mode_nxt;
  coord_t                     cur_x_r, cur_x_nxt;
  coord_t                     cur_y_r, cur_y_nxt;
  coord_t                     dx_r, dx_nxt;
  coord_t                     dy_r, dy_nxt;
  logic                       x_neg_r, x_neg_nxt;
  logic                       y_neg_r, y_neg_nxt;
  logic signed [ERR_BITS-1:0] err_r, err_nxt;
  coord_t                     run_left_r, run_left_nxt;
  color_t                     color_r, color_nxt;

  // start set-up terms
  logic                       s_x_neg;
  logic                       s_y_neg;
  coord_t                     s_dx;
  coord_t                     s_dy;
  logic signed [ERR_BITS-1:0] s_dx2;
  logic signed [ERR_BITS-1:0] s_dy2;

  // stepping terms
  logic signed [ERR_BITS-1:0] dx2;
  logic signed [ERR_BITS-1:0] dy2;
  logic                       is_last;

  function automatic coord_t step_coord(input coord_t c, input logic neg);
    return neg ? c - coord_t'(1) : c + coord_t'(1);
  endfunction

  assign s_x_neg = in_x_start >= in_x_end;
  assign s_y_neg = in_y_start >= in_y_end;
  assign s_dx    = s_x_neg ? in_x_start - in_x_end : in_x_end - in_x_start;
  assign s_dy    = s_y_neg ? in_y_start - in_y_end : in_y_end - in_y_start;
  assign s_dx2   = signed'(ERR_BITS'({s_dx, 1'b0}));
  assign s_dy2   = signed'(ERR_BITS'({s_dy, 1'b0}));

  assign dx2     = signed'(ERR_BITS'({dx_r, 1'b0}));
  assign dy2     = signed'(ERR_BITS'({dy_r, 1'b0}));
  assign is_last = (run_left_r == '0);

  assign pix = '{x: cur_x_r, y: cur_y_r, color: color_r, last: is_last};

  // classify start transactions, step the line on ticks
  always_comb begin
    active_nxt   = active_r;
    mode_nxt     = mode_r;
    cur_x_nxt    = cur_x_r;
    cur_y_nxt    = cur_y_r;
    dx_nxt       = dx_r;
    dy_nxt       = dy_r;
    x_neg_nxt    = x_neg_r;
    y_neg_nxt    = y_neg_r;
    err_nxt      = err_r;
    run_left_nxt = run_left_r;
    color_nxt    = color_r;
    pix_push     = 1'b0;
    if (accept) begin
      if (in_kind == KIND_START) begin
        color_nxt = in_line_color;
        x_neg_nxt = s_x_neg;
        y_neg_nxt = s_y_neg;
        dx_nxt    = s_dx;
        dy_nxt    = s_dy;
        err_nxt   = '0;
        if (in_y_start == in_y_end) begin
          mode_nxt     = MODE_H;
          cur_x_nxt    = s_x_neg ? in_x_end : in_x_start;
          cur_y_nxt    = in_y_start;
          active_nxt   = (s_dx != '0);
          run_left_nxt = s_dx - coord_t'(1);
        end else if (in_x_start == in_x_end) begin
          mode_nxt     = MODE_V;
          cur_x_nxt    = in_x_start;
          cur_y_nxt    = s_y_neg ? in_y_end : in_y_start;
          active_nxt   = 1'b1;
          run_left_nxt = s_dy - coord_t'(1);
        end else begin
          cur_x_nxt  = in_x_start;
          cur_y_nxt  = in_y_start;
          active_nxt = 1'b1;
          if (s_dy >= s_dx) begin
            mode_nxt     = MODE_YMAJ;
            err_nxt      = s_dx2 - signed'(ERR_BITS'(s_dy));
            run_left_nxt = s_dy;
          end else begin
            mode_nxt     = MODE_XMAJ;
            err_nxt      = s_dy2 - signed'(ERR_BITS'(s_dx));
            run_left_nxt = s_dx;
          end
        end
      end else if (active_r) begin
        pix_push = 1'b1;
        if (is_last) begin
          active_nxt = 1'b0;
        end else begin
          run_left_nxt = run_left_r - coord_t'(1);
          case (mode_r)
            MODE_H: begin
              cur_x_nxt = cur_x_r + coord_t'(1);
            end
            MODE_V: begin
              cur_y_nxt = cur_y_r + coord_t'(1);
            end
            MODE_YMAJ: begin
              cur_y_nxt = step_coord(cur_y_r, y_neg_r);
              if (err_r < 0) begin
                err_nxt = err_r + dx2;
              end else begin
                cur_x_nxt = step_coord(cur_x_r, x_neg_r);
                err_nxt   = err_r + dx2 - dy2;
              end
            end
            default: begin
              cur_x_nxt = step_coord(cur_x_r, x_neg_r);
              if (err_r < 0) begin
                err_nxt = err_r + dy2;
              end else begin
                cur_y_nxt = step_coord(cur_y_r, y_neg_r);
                err_nxt   = err_r + dy2 - dx2;
              end
            end
          endcase
        end
      end
    end
  end

  // control state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      active_r <= 1'b0;
      mode_r   <= MODE_H;
    end else begin
      active_r <= active_nxt;
      mode_r   <= mode_nxt;
    end
  end

  // line registers
  always_ff @(posedge clk) begin
    cur_x_r    <= cur_x_nxt;
    cur_y_r    <= cur_y_nxt;
    dx_r       <= dx_nxt;
    dy_r       <= dy_nxt;
    x_neg_r    <= x_neg_nxt;
    y_neg_r    <= y_neg_nxt;
    err_r      <= err_nxt;
    run_left_r <= run_left_nxt;
    color_r    <= color_nxt;
  end

endmodule

@@ hw/rtl/blr_queue.sv @@
module blr_queue
  import blr_pkg::*;
(
  input  logic clk,
  input  logic rst_n,
  input  logic wr_en,
  input  pix_t wr_data,
  output logic full,
  input  logic rd_en,
  output pix_t rd_data,
  output logic empty
);

  pix_t                  mem [Q_DEPTH];
  logic [Q_PTR_BITS-1:0] wr_ptr_r, wr_ptr_nxt;
  logic [Q_PTR_BITS-1:0] rd_ptr_r, rd_ptr_nxt;
  logic [Q_CNT_BITS-1:0] cnt_r, cnt_nxt;
  logic                  do_wr;
  logic                  do_rd;

  assign full    = (cnt_r == Q_CNT_BITS'(Q_DEPTH));
  assign empty   = (cnt_r == '0);
  assign rd_data = mem[rd_ptr_r];
  assign do_wr   = wr_en && !full;
  assign do_rd   = rd_en && !empty;

  // pointer and fill level update
  always_comb begin
    wr_ptr_nxt = do_wr ? wr_ptr_r + Q_PTR_BITS'(1) : wr_ptr_r;
    rd_ptr_nxt = do_rd ? rd_ptr_r + Q_PTR_BITS'(1) : rd_ptr_r;
    cnt_nxt    = cnt_r;
    if (do_wr && !do_rd) begin
      cnt_nxt = cnt_r + Q_CNT_BITS'(1);
    end else if (do_rd && !do_wr) begin
      cnt_nxt = cnt_r - Q_CNT_BITS'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      cnt_r    <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      cnt_r    <= cnt_nxt;
    end
  end

  // storage
  always_ff @(posedge clk) begin
    if (do_wr) begin
      mem[wr_ptr_r] <= wr_data;
    end
  end

endmodule

@@ hw/rtl/blr_back.sv @@
module blr_back
  import blr_pkg::*;
(
  input  logic   clk,
  input  logic   rst_n,
  input  logic   cfg_wr_en,
  input  pitch_t cfg_row_pitch,
  input  logic   q_empty,
  input  pix_t   q_data,
  output logic   q_pop,
  output index_t out_pixel_index,
  output color_t out_pixel_color,
  output logic   out_last_pixel,
  output logic   empty,
  input  logic   pop
);

  pitch_t              pitch_r;
  logic [SUM_BITS-1:0] sum;
  wr_t                 wr;
  wr_t                 buf_mem [2];
  logic                wr_ptr_r;
  logic                rd_ptr_r;
  logic [1:0]          cnt_r, cnt_nxt;
  logic                do_pop;

  // row pitch register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pitch_r <= PITCH_RESET;
    end else if (cfg_wr_en) begin
      pitch_r <= cfg_row_pitch;
    end
  end

  // linear index, wrapped to the index width
  assign sum = SUM_BITS'(pitch_r) * SUM_BITS'(q_data.y) + SUM_BITS'(q_data.x);
  assign wr  = '{index: sum[INDEX_BITS-1:0], color: q_data.color, last: q_data.last};

  // two-entry output buffer, refilled while the head is taken
  assign empty  = (cnt_r == 2'd0);
  assign do_pop = pop && !empty;
  assign q_pop  = !q_empty && ((cnt_r != 2'd2) || do_pop);

  assign out_pixel_index = buf_mem[rd_ptr_r].index;
  assign out_pixel_color = buf_mem[rd_ptr_r].color;
  assign out_last_pixel  = buf_mem[rd_ptr_r].last;

  always_comb begin
    cnt_nxt = cnt_r;
    if (q_pop && !do_pop) begin
      cnt_nxt = cnt_r + 2'd1;
    end else if (do_pop && !q_pop) begin
      cnt_nxt = cnt_r - 2'd1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= 1'b0;
      rd_ptr_r <= 1'b0;
      cnt_r    <= 2'd0;
    end else begin
      wr_ptr_r <= q_pop ? !wr_ptr_r : wr_ptr_r;
      rd_ptr_r <= do_pop ? !rd_ptr_r : rd_ptr_r;
      cnt_r    <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (q_pop) begin
      buf_mem[wr_ptr_r] <= wr;
    end
  end

endmodule

@@ hw/rtl/bresenham_line_raster.sv @@
// Line rasteriser for a 16-bit framebuffer, seen as a queue on both sides.
// Input: a transaction is taken when push is high and full is low. A start
// transaction (in_kind low) loads the endpoints and colour and gives no
// output; each tick transaction (in_kind high) gives one pixel write while a
// line is running, and nothing while idle. A new start drops any line in
// progress. Horizontal and vertical runs leave out the far end; other lines
// include both endpoints.
// Output: the oldest pixel write sits on out_* while empty is low and is
// taken when pop is high. out_pixel_index is x + row_pitch * y, low 24 bits.
// Config: cfg_row_pitch is written when cfg_wr_en is high; write it only
// while idle, which the block itself does not enforce. Throughput is one
// transaction per cycle on both sides while full and empty are low; a pixel
// passes the queue, then the pitch multiply into the output buffer, before
// reaching the outputs. A stalled receiver fills the two-entry output buffer
// and then the four-entry queue behind the stepper, after which full rises.
// Reset (rst_n low, synchronous) empties both queues, leaves the stepper
// idle and sets row_pitch to 640.
module bresenham_line_raster
  import blr_pkg::*;
(
  input  logic   clk,
  input  logic   rst_n,
  input  logic   cfg_wr_en,
  input  pitch_t cfg_row_pitch,
  input  logic   push,
  output logic   full,
  input  logic   in_kind,
  input  coord_t in_x_start,
  input  coord_t in_y_start,
  input  coord_t in_x_end,
  input  coord_t in_y_end,
  input  color_t in_line_color,
  output logic   empty,
  input  logic   pop,
  output index_t out_pixel_index,
  output color_t out_pixel_color,
  output logic   out_last_pixel
);

  logic accept;
  logic pix_push;
  pix_t pix;
  logic q_pop;
  pix_t q_data;
  logic q_empty;

  assign accept = push && !full;

  // front: classify and step
  blr_front u_front (
    .clk          (clk),
    .rst_n        (rst_n),
    .accept       (accept),
    .in_kind      (in_kind),
    .in_x_start   (in_x_start),
    .in_y_start   (in_y_start),
    .in_x_end     (in_x_end),
    .in_y_end     (in_y_end),
    .in_line_color(in_line_color),
    .pix_push     (pix_push),
    .pix          (pix)
  );

  // decoupling queue
  blr_queue u_queue (
    .clk    (clk),
    .rst_n  (rst_n),
    .wr_en  (pix_push),
    .wr_data(pix),
    .full   (full),
    .rd_en  (q_pop),
    .rd_data(q_data),
    .empty  (q_empty)
  );

  // back: index computation and output buffer
  blr_back u_back (
    .clk            (clk),
    .rst_n          (rst_n),
    .cfg_wr_en      (cfg_wr_en),
    .cfg_row_pitch  (cfg_row_pitch),
    .q_empty        (q_empty),
    .q_data         (q_data),
    .q_pop          (q_pop),
    .out_pixel_index(out_pixel_index),
    .out_pixel_color(out_pixel_color),
    .out_last_pixel (out_last_pixel),
    .empty          (empty),
    .pop            (pop)
  );

endmodule

@@ sim/blr_pixel_checker.sv @@
`timescale 1ns / 1ps

module blr_pixel_checker
  import blr_pkg::*;
(
  input  logic        clk,
  input  logic        rst_n,
  input  logic        cfg_wr_en,
  input  pitch_t      cfg_row_pitch,
  input  logic        push,
  input  logic        full,
  input  logic        in_kind,
  input  coord_t      in_x_start,
  input  coord_t      in_y_start,
  input  coord_t      in_x_end,
  input  coord_t      in_y_end,
  input  color_t      in_line_color,
  input  logic        empty,
  input  logic        pop,
  input  index_t      out_pixel_index,
  input  color_t      out_pixel_color,
  input  logic        out_last_pixel,
  output int unsigned error_count,
  output int unsigned writes_outstanding
);

  typedef enum logic [1:0] {
    RUN_HORIZ,
    RUN_VERT,
    RUN_STEEP,
    RUN_SHALLOW
  } run_shape_t;

  // predicted rasteriser state
  pitch_t     pitch_now;
  logic       drawing;
  run_shape_t shape;
  coord_t     pos_x;
  coord_t     pos_y;
  coord_t     span_x;
  coord_t     span_y;
  logic       x_down;
  logic       y_down;
  int         decision;
  coord_t     pixels_after;
  color_t     ink;

  // pixel writes predicted but not yet seen on the output
  wr_t expected_writes[$];

  function automatic coord_t nudge(input coord_t c, input logic down);
    return down ? c - 1'b1 : c + 1'b1;
  endfunction

  task automatic clear_state();
    pitch_now    = PITCH_RESET;
    drawing      = 1'b0;
    shape        = RUN_HORIZ;
    pos_x        = '0;
    pos_y        = '0;
    span_x       = '0;
    span_y       = '0;
    x_down       = 1'b0;
    y_down       = 1'b0;
    decision     = 0;
    pixels_after = '0;
    ink          = '0;
  endtask

  // latch a new line, dropping whatever was in progress
  task automatic load_line(input coord_t x0, y0, x1, y1, input color_t col);
    logic [COORD_BITS:0] count;
    ink      = col;
    x_down   = x0 >= x1;
    y_down   = y0 >= y1;
    span_x   = x_down ? x0 - x1 : x1 - x0;
    span_y   = y_down ? y0 - y1 : y1 - y0;
    decision = 0;
    if (y0 == y1) begin
      // horizontal run from the smaller x, far end left out
      shape = RUN_HORIZ;
      pos_x = (x0 <= x1) ? x0 : x1;
      pos_y = y0;
      count = {1'b0, span_x};
    end else if (x0 == x1) begin
      // vertical run from the smaller y, far end left out
      shape = RUN_VERT;
      pos_x = x0;
      pos_y = (y0 <= y1) ? y0 : y1;
      count = {1'b0, span_y};
    end else begin
      // general line, both endpoints drawn
      pos_x = x0;
      pos_y = y0;
      if (span_y >= span_x) begin
        shape    = RUN_STEEP;
        decision = 2 * int'(span_x) - int'(span_y);
        count    = {1'b0, span_y} + 1'b1;
      end else begin
        shape    = RUN_SHALLOW;
        decision = 2 * int'(span_y) - int'(span_x);
        count    = {1'b0, span_x} + 1'b1;
      end
    end
    drawing      = count != 0;
    pixels_after = drawing ? coord_t'(count - 1'b1) : '0;
  endtask

  // one tick: predict a pixel write and move along the line
  task automatic tick_pixel();
    wr_t w;
    if (!drawing) return;
    w.index = index_t'(32'(pos_x) + 32'(pitch_now) * 32'(pos_y));
    w.color = ink;
    w.last  = pixels_after == 0;
    expected_writes.push_back(w);
    if (w.last) begin
      drawing = 1'b0;
    end else begin
      pixels_after = pixels_after - 1'b1;
      case (shape)
        RUN_HORIZ: pos_x = pos_x + 1'b1;
        RUN_VERT:  pos_y = pos_y + 1'b1;
        RUN_STEEP: begin
          pos_y = nudge(pos_y, y_down);
          if (decision < 0) begin
            decision += 2 * int'(span_x);
          end else begin
            pos_x = nudge(pos_x, x_down);
            decision += 2 * (int'(span_x) - int'(span_y));
          end
        end
        default: begin
          pos_x = nudge(pos_x, x_down);
          if (decision < 0) begin
            decision += 2 * int'(span_y);
          end else begin
            pos_y = nudge(pos_y, y_down);
            decision += 2 * (int'(span_y) - int'(span_x));
          end
        end
      endcase
    end
  endtask

  // compare an output transaction with the oldest prediction
  task automatic check_write();
    wr_t w;
    if (expected_writes.size() == 0) begin
      $error("unexpected pixel write: index %0h colour %0h last %0b",
             out_pixel_index, out_pixel_color, out_last_pixel);
      error_count++;
      return;
    end
    w = expected_writes.pop_front();
    if (out_pixel_index !== w.index) begin
      $error("pixel_index: expected %0h, got %0h", w.index, out_pixel_index);
      error_count++;
    end
    if (out_pixel_color !== w.color) begin
      $error("pixel_color: expected %0h, got %0h", w.color, out_pixel_color);
      error_count++;
    end
    if (out_last_pixel !== w.last) begin
      $error("last_pixel: expected %0b, got %0b", w.last, out_last_pixel);
      error_count++;
    end
  endtask

  // watch all three ports at the rising edge
  always @(posedge clk) begin
    if (!rst_n) begin
      clear_state();
      expected_writes.delete();
    end else begin
      if (cfg_wr_en) pitch_now = cfg_row_pitch;
      if (pop && !empty) check_write();
      if (push && !full) begin
        if (in_kind == KIND_START)
          load_line(in_x_start, in_y_start, in_x_end, in_y_end, in_line_color);
        else
          tick_pixel();
      end
    end
    writes_outstanding = expected_writes.size();
  end

endmodule

@@ sim/bresenham_line_raster_tb.sv @@
`timescale 1ns / 1ps

module bresenham_line_raster_tb;
  import blr_pkg::*;

  localparam int unsigned IDLE_PCT       = 28;
  localparam int unsigned RX_HOLD_CYCLES = 80;
  localparam int unsigned SETTLE_CYCLES  = 8;
  localparam int unsigned WATCHDOG_LIMIT = 3000;

  logic   clk;
  logic   rst_n;
  logic   cfg_wr_en;
  pitch_t cfg_row_pitch;
  logic   push;
  logic   full;
  logic   in_kind;
  coord_t in_x_start;
  coord_t in_y_start;
  coord_t in_x_end;
  coord_t in_y_end;
  color_t in_line_color;
  logic   empty;
  logic   pop;
  index_t out_pixel_index;
  color_t out_pixel_color;
  logic   out_last_pixel;

  int unsigned error_count;
  int unsigned writes_outstanding;
  int unsigned items_sent;

  // idling controls for the sender and the receiver
  logic tx_steady;
  logic rx_steady;
  logic rx_hold_req;
  logic rx_hold_done;

  bresenham_line_raster dut (
    .clk             (clk),
    .rst_n           (rst_n),
    .cfg_wr_en       (cfg_wr_en),
    .cfg_row_pitch   (cfg_row_pitch),
    .push            (push),
    .full            (full),
    .in_kind         (in_kind),
    .in_x_start      (in_x_start),
    .in_y_start      (in_y_start),
    .in_x_end        (in_x_end),
    .in_y_end        (in_y_end),
    .in_line_color   (in_line_color),
    .empty           (empty),
    .pop             (pop),
    .out_pixel_index (out_pixel_index),
    .out_pixel_color (out_pixel_color),
    .out_last_pixel  (out_last_pixel)
  );

  blr_pixel_checker pixel_check (
    .clk                (clk),
    .rst_n              (rst_n),
    .cfg_wr_en          (cfg_wr_en),
    .cfg_row_pitch      (cfg_row_pitch),
    .push               (push),
    .full               (full),
    .in_kind            (in_kind),
    .in_x_start         (in_x_start),
    .in_y_start         (in_y_start),
    .in_x_end           (in_x_end),
    .in_y_end           (in_y_end),
    .in_line_color      (in_line_color),
    .empty              (empty),
    .pop                (pop),
    .out_pixel_index    (out_pixel_index),
    .out_pixel_color    (out_pixel_color),
    .out_last_pixel     (out_last_pixel),
    .error_count        (error_count),
    .writes_outstanding (writes_outstanding)
  );

  // 2 ns clock
  always begin
    clk = 1'b0;
    #1;
    clk = 1'b1;
    #1;
  end

  // receiver: random pops, one long hold-off on request
  initial begin
    pop          = 1'b0;
    rx_hold_done = 1'b0;
    forever begin
      @(negedge clk);
      if (rx_hold_req && !rx_hold_done) begin
        pop <= 1'b0;
        repeat (RX_HOLD_CYCLES - 1) @(negedge clk);
        rx_hold_done = 1'b1;
      end else if (rx_steady) begin
        pop <= 1'b1;
      end else begin
        pop <= $urandom_range(0, 99) >= IDLE_PCT;
      end
    end
  end

  // drive one input transaction and wait until it is taken
  task automatic send_item(input logic kind, input coord_t x0, y0, x1, y1,
                           input color_t col);
    @(negedge clk);
    while (!tx_steady && $urandom_range(0, 99) < IDLE_PCT) begin
      push <= 1'b0;
      @(negedge clk);
    end
    push          <= 1'b1;
    in_kind       <= kind;
    in_x_start    <= x0;
    in_y_start    <= y0;
    in_x_end      <= x1;
    in_y_end      <= y1;
    in_line_color <= col;
    do @(posedge clk); while (full);
    items_sent++;
  endtask

  // tick with junk in the unused fields
  task automatic send_tick();
    send_item(KIND_TICK, coord_t'($urandom), coord_t'($urandom), coord_t'($urandom),
              coord_t'($urandom), color_t'($urandom));
  endtask

  // hold the input off until every predicted write has come out
  task automatic wait_drained();
    do begin
      @(negedge clk);
      push <= 1'b0;
    end while (writes_outstanding != 0);
    repeat (SETTLE_CYCLES) @(negedge clk);
  endtask

  task automatic set_pitch(input pitch_t value);
    wait_drained();
    cfg_wr_en     <= 1'b1;
    cfg_row_pitch <= value;
    @(negedge clk);
    cfg_wr_en <= 1'b0;
  endtask

  // edges of the coordinate range turn up often
  function automatic coord_t pick_coord();
    case ($urandom_range(0, 9))
      0:       return '0;
      1:       return '1;
      default: return coord_t'($urandom);
    endcase
  endfunction

  // one start followed by ticks, now and then a stray transaction
  task automatic random_line();
    coord_t      x0, y0, x1, y1, dx, dy;
    int unsigned pick, reach, pixels, ticks;
    pick = $urandom_range(0, 99);
    if (pick < 8) begin
      send_item($urandom_range(0, 1) ? KIND_TICK : KIND_START, coord_t'($urandom),
                coord_t'($urandom), coord_t'($urandom), coord_t'($urandom),
                color_t'($urandom));
      return;
    end
    x0    = pick_coord();
    y0    = pick_coord();
    reach = ($urandom_range(0, 19) == 0) ? 4095 : 12;
    x1    = coord_t'(x0 + $urandom_range(0, 2 * reach) - reach);
    y1    = coord_t'(y0 + $urandom_range(0, 2 * reach) - reach);
    if (pick < 34)
      y1 = y0;
    else if (pick < 56)
      x1 = x0;
    dx = (x0 >= x1) ? x0 - x1 : x1 - x0;
    dy = (y0 >= y1) ? y0 - y1 : y1 - y0;
    if (y0 == y1)
      pixels = dx;
    else if (x0 == x1)
      pixels = dy;
    else
      pixels = ((dx > dy) ? dx : dy) + 1;
    // mostly run the line out, sometimes cut it short with the next start
    ticks = pixels + $urandom_range(0, 2);
    if ($urandom_range(0, 99) < 15) ticks = $urandom_range(0, pixels);
    if (ticks > 40) ticks = 40;
    send_item(KIND_START, x0, y0, x1, y1, color_t'($urandom));
    repeat (ticks) send_tick();
  endtask

  task automatic random_phase(input int unsigned count);
    int unsigned goal;
    goal = items_sent + count;
    while (items_sent < goal) random_line();
  endtask

  // watchdog on cycles with no transaction anywhere
  initial begin : watchdog
    int unsigned quiet;
    quiet = 0;
    while (quiet < WATCHDOG_LIMIT) begin
      @(posedge clk);
      if (!rst_n || (push && !full) || (pop && !empty))
        quiet = 0;
      else
        quiet++;
    end
    $display("FAIL");
    $finish;
  end

  // stimulus
  initial begin
    rst_n         = 1'b0;
    cfg_wr_en     = 1'b0;
    cfg_row_pitch = PITCH_RESET;
    push          = 1'b0;
    in_kind       = KIND_TICK;
    in_x_start    = '0;
    in_y_start    = '0;
    in_x_end      = '0;
    in_y_end      = '0;
    in_line_color = '0;
    tx_steady     = 1'b0;
    rx_steady     = 1'b0;
    rx_hold_req   = 1'b0;
    items_sent    = 0;
    repeat (3) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    // tick while idle straight after reset
    send_tick();
    // horizontal run left to right, far end left out, tick past the end
    send_item(KIND_START, 0, 0, 3, 0, 16'hFFFF);
    repeat (4) send_tick();
    // horizontal run given right to left at the top corner
    send_item(KIND_START, 4095, 4095, 4093, 4095, 16'h0000);
    repeat (2) send_tick();
    // vertical run given bottom to top
    send_item(KIND_START, 4095, 7, 4095, 5, 16'h1234);
    repeat (2) send_tick();
    // zero-length run stays idle
    send_item(KIND_START, 100, 100, 100, 100, 16'hBEEF);
    send_tick();
    // shallow line stepping up in y
    send_item(KIND_START, 0, 4095, 3, 4093, 16'h5A5A);
    repeat (4) send_tick();
    // steep line stepping down in x, dropped part way by a diagonal
    send_item(KIND_START, 4095, 0, 4093, 3, 16'hA5A5);
    repeat (2) send_tick();
    send_item(KIND_START, 5, 5, 7, 7, 16'h8001);
    repeat (3) send_tick();

    // receiver stalls while a long line keeps coming, input backs up
    wait_drained();
    rx_hold_req = 1'b1;
    send_item(KIND_START, 0, 0, 200, 37, 16'hC3C3);
    repeat (40) send_tick();
    send_item(KIND_START, 9, 9, 9, 9, 16'h0F0F);

    // random traffic over a spread of row pitches
    set_pitch(13'd1);
    random_phase(180);
    set_pitch(13'd4096);
    random_phase(180);
    set_pitch(13'd0);
    tx_steady = 1'b1;
    rx_steady = 1'b1;
    random_phase(160);
    tx_steady = 1'b0;
    rx_steady = 1'b0;
    set_pitch(13'd8191);
    random_phase(180);
    set_pitch(pitch_t'($urandom_range(1, 4096)));
    random_phase(180);
    set_pitch(pitch_t'($urandom));
    random_phase(160);
    set_pitch(PITCH_RESET);
    random_phase(140);

    wait_drained();
    if (error_count == 0)
      $display("PASS");
    else
      $display("FAIL");
    $finish;
  end

endmodule
